// File: sv/brfom_pkg.sv
// Shared types and constants for the byte ring FIFO with overwrite and pattern match.
// Used by the front, queue, back and top-level modules. No dependencies.
package brfom_pkg;

    // Ring geometry.
    localparam int SLOTS  = 64;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int LEN_W  = ADDR_W + 1;

    // Fixed field widths of the command, item, result and configuration beats.
    localparam int CMD_W  = 4;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 8;
    localparam int CNT_W  = 6;
    localparam int CFG_W  = 7;

    // Largest byte count streamed by one pop or peek.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Ring length after reset and the smallest legal ring length.
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(SLOTS);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP_DROP  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP_COPY  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_COPY = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_NTH  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REPLACE   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_BEGINS    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ENDS      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_NOP       = 4'd15;

    // Queue between front and back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // A classified command as it travels from front to back.
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  req;
        logic [CNT_W-1:0]  offset;
        logic [CNT_W-1:0]  plen;
        logic              plast;
    } item_t;

endpackage

// File: sv/brfom_front.sv
// Front end: accepts command beats and classifies them into queue items.
// Depends on brfom_pkg.
module brfom_front import brfom_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [REQ_W-1:0]  s_request_count,
    input  logic [CNT_W-1:0]  s_offset,
    input  logic [CNT_W-1:0]  s_pattern_length,
    input  logic              s_pattern_last,
    output logic              f_valid,
    output item_t             f_item,
    input  logic              f_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign s_ready = !valid_reg || f_ready;
    assign take    = s_valid && s_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    // Classify: unknown codes fold into a no-op and the request saturates
    // at the streaming limit, which the fill level never exceeds anyway.
    always_comb begin
        item_next        = item_reg;
        item_next.op     = (s_command > CMD_ENDS) ? CMD_NOP : s_command;
        item_next.data   = s_data_byte;
        item_next.req    = (s_request_count > REQ_W'(CNT_MAX)) ? CNT_MAX
                                                               : CNT_W'(s_request_count);
        item_next.offset = s_offset;
        item_next.plen   = s_pattern_length;
        item_next.plast  = s_pattern_last;
    end

    // Stage valid flag.
    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: sv/brfom_queue.sv
// Short queue of classified items between the front and the back end.
// Depends on brfom_pkg.
module brfom_queue import brfom_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: sv/brfom_back.sv
// Back end: sequencer that owns the byte store, the ring pointers, the match
// flag and the result register. Depends on brfom_pkg.
module brfom_back import brfom_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    input  logic              upstream_busy,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_buffer_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_out,
    output logic              m_byte_valid,
    output logic              m_last_of_run,
    output logic [CNT_W-1:0]  m_done_count,
    output logic              m_match_found,
    output logic              m_offset_error,
    output logic [CNT_W-1:0]  m_fill_level
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]        state_reg,     state_next;
    item_t             item_reg,      item_next;
    logic [ADDR_W-1:0] head_reg,      head_next;
    logic [ADDR_W-1:0] tail_reg,      tail_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic              match_run_reg, match_run_next;
    logic [SLOTS-1:0]  vld_bits_reg,  vld_bits_next;
    logic [ADDR_W-1:0] rd_addr_reg,   rd_addr_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [CNT_W-1:0]  done_reg,      done_next;
    logic              res_byte_reg,  res_byte_next;
    logic              res_err_reg,   res_err_next;
    logic              res_match_reg, res_match_next;
    logic              stream_reg,    stream_next;
    logic              cmp_reg,       cmp_next;
    logic              ok_reg,        ok_next;
    logic              m_valid_reg,   m_valid_next;

    logic [BYTE_W-1:0] m_byte_out_reg,     m_byte_out_next;
    logic              m_byte_valid_reg,   m_byte_valid_next;
    logic              m_last_of_run_reg,  m_last_of_run_next;
    logic [CNT_W-1:0]  m_done_count_reg,   m_done_count_next;
    logic              m_match_found_reg,  m_match_found_next;
    logic              m_offset_error_reg, m_offset_error_next;
    logic [CNT_W-1:0]  m_fill_level_reg,   m_fill_level_next;

    logic [BYTE_W-1:0] mem [SLOTS];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;

    logic [LEN_W-1:0]  fill_wide;
    logic [ADDR_W-1:0] fill;
    logic [CNT_W-1:0]  fill_cnt;
    logic [CNT_W-1:0]  take_cnt;
    logic [ADDR_W-1:0] tail_inc;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] nth_idx;
    logic              off_err;
    logic [LEN_W-1:0]  end_start_wide;
    logic [ADDR_W-1:0] match_idx;
    logic              is_pattern;
    logic [BYTE_W-1:0] rd_byte;
    logic              out_free;
    logic              cmp_ok;
    logic [LEN_W-1:0]  len_clamp;

    // Sum of two ring positions, folded once into the ring.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b,
                                                   input logic [LEN_W-1:0]  len);
        logic [LEN_W:0] s;
        s = (LEN_W+1)'(a) + (LEN_W+1)'(b);
        if (s >= (LEN_W+1)'(len)) begin
            s = s - (LEN_W+1)'(len);
        end
        return ADDR_W'(s);
    endfunction

    // Fill level and the addresses derived from the current item.
    assign fill_wide = LEN_W'(tail_reg) + ((tail_reg < head_reg) ? len_reg : '0)
                     - LEN_W'(head_reg);
    assign fill      = ADDR_W'(fill_wide);
    assign fill_cnt  = CNT_W'(fill);
    assign take_cnt  = (item_reg.req < fill_cnt) ? item_reg.req : fill_cnt;
    assign tail_inc  = ring_add(tail_reg, ADDR_W'(1), len_reg);
    assign head_inc  = ring_add(head_reg, ADDR_W'(1), len_reg);
    assign off_err   = (LEN_W'(item_reg.offset) >= len_reg);
    assign nth_idx   = ring_add(head_reg, ADDR_W'(item_reg.offset), len_reg);

    // Ends-with starts plen bytes before the tail; only used when plen <= fill.
    assign end_start_wide = LEN_W'(tail_reg)
                          + ((LEN_W'(tail_reg) < LEN_W'(item_reg.plen)) ? len_reg : '0)
                          - LEN_W'(item_reg.plen);
    assign match_idx = ring_add((item_reg.op == CMD_BEGINS) ? head_reg
                                                           : ADDR_W'(end_start_wide),
                                ADDR_W'(item_reg.offset), len_reg);

    assign is_pattern = (item_reg.op == CMD_BEGINS) || (item_reg.op == CMD_ENDS);
    assign rd_byte    = rd_vld_reg ? rd_data_reg : '0;
    assign out_free   = !m_valid_reg || m_ready;
    assign cmp_ok     = ok_reg && (!cmp_reg || (rd_byte == item_reg.data));

    // Register value held to the legal ring lengths.
    always_comb begin
        len_clamp = LEN_W'(cfg_buffer_length);
        if (LEN_W'(cfg_buffer_length) < LEN_MIN) begin
            len_clamp = LEN_MIN;
        end else if (LEN_W'(cfg_buffer_length) > LEN_W'(SLOTS)) begin
            len_clamp = LEN_W'(SLOTS);
        end
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !q_valid && !upstream_busy && !m_valid_reg;

    // Sequencer.
    always_comb begin
        state_next          = state_reg;
        item_next           = item_reg;
        head_next           = head_reg;
        tail_next           = tail_reg;
        len_next            = len_reg;
        match_run_next      = match_run_reg;
        vld_bits_next       = vld_bits_reg;
        rd_addr_next        = rd_addr_reg;
        cnt_next            = cnt_reg;
        done_next           = done_reg;
        res_byte_next       = res_byte_reg;
        res_err_next        = res_err_reg;
        res_match_next      = res_match_reg;
        stream_next         = stream_reg;
        cmp_next            = cmp_reg;
        ok_next             = ok_reg;
        m_valid_next        = m_valid_reg;
        m_byte_out_next     = m_byte_out_reg;
        m_byte_valid_next   = m_byte_valid_reg;
        m_last_of_run_next  = m_last_of_run_reg;
        m_done_count_next   = m_done_count_reg;
        m_match_found_next  = m_match_found_reg;
        m_offset_error_next = m_offset_error_reg;
        m_fill_level_next   = m_fill_level_reg;
        mem_we              = 1'b0;
        mem_waddr           = tail_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_byte_next  = 1'b0;
                res_err_next   = 1'b0;
                res_match_next = 1'b0;
                stream_next    = 1'b0;
                done_next      = '0;
                cnt_next       = '0;
                state_next     = ST_RESP;
                if (!is_pattern) begin
                    match_run_next = 1'b1;
                end
                unique case (item_reg.op) inside
                    CMD_PUSH: begin
                        mem_we    = 1'b1;
                        mem_waddr = tail_reg;
                        tail_next = tail_inc;
                        // A full ring drops its oldest byte.
                        if (tail_inc == head_reg) begin
                            head_next = head_inc;
                        end
                    end
                    CMD_POP_DROP: begin
                        head_next = ring_add(head_reg, ADDR_W'(take_cnt), len_reg);
                        done_next = take_cnt;
                    end
                    CMD_POP_COPY, CMD_PEEK_COPY: begin
                        if (item_reg.op == CMD_POP_COPY) begin
                            head_next = ring_add(head_reg, ADDR_W'(take_cnt), len_reg);
                        end
                        done_next = take_cnt;
                        if (take_cnt != '0) begin
                            res_byte_next = 1'b1;
                            stream_next   = 1'b1;
                            cnt_next      = take_cnt;
                            rd_addr_next  = head_reg;
                            state_next    = ST_READ;
                        end
                    end
                    CMD_PEEK_NTH: begin
                        if (off_err) begin
                            res_err_next = 1'b1;
                        end else begin
                            res_byte_next = 1'b1;
                            rd_addr_next  = nth_idx;
                            state_next    = ST_READ;
                        end
                    end
                    CMD_REPLACE: begin
                        if (off_err) begin
                            res_err_next = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = nth_idx;
                        end
                    end
                    CMD_CLEAR: begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    CMD_BEGINS, CMD_ENDS: begin
                        ok_next    = match_run_reg;
                        cmp_next   = 1'b0;
                        state_next = ST_CMP;
                        // A pattern longer than the stored bytes never matches.
                        if (item_reg.plen > fill_cnt) begin
                            ok_next = 1'b0;
                        end else if (item_reg.offset < item_reg.plen) begin
                            cmp_next     = 1'b1;
                            rd_addr_next = match_idx;
                            state_next   = ST_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_READ: begin
                state_next = is_pattern ? ST_CMP : ST_RESP;
            end

            ST_CMP: begin
                if (item_reg.plast) begin
                    match_run_next = 1'b1;
                    res_match_next = cmp_ok;
                    state_next     = ST_RESP;
                end else begin
                    match_run_next = cmp_ok;
                    state_next     = ST_IDLE;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_byte_out_next     = res_byte_reg ? rd_byte : '0;
                    m_byte_valid_next   = res_byte_reg;
                    m_last_of_run_next  = !stream_reg || (cnt_reg == CNT_W'(1));
                    m_done_count_next   = done_reg;
                    m_match_found_next  = res_match_reg;
                    m_offset_error_next = res_err_reg;
                    m_fill_level_next   = CNT_W'(fill);
                    // Stream on through the ring until the count runs out.
                    if (stream_reg && (cnt_reg != CNT_W'(1))) begin
                        cnt_next     = cnt_reg - 1'b1;
                        rd_addr_next = ring_add(rd_addr_reg, ADDR_W'(1), len_reg);
                        state_next   = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Any written slot now holds real data.
        if (mem_we) begin
            vld_bits_next[mem_waddr] = 1'b1;
        end

        // A register write empties the ring but keeps the stored bytes.
        if (cfg_valid && cfg_ready) begin
            len_next       = len_clamp;
            head_next      = '0;
            tail_next      = '0;
            match_run_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= LEN_RESET;
            match_run_reg <= 1'b1;
            vld_bits_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            len_reg       <= len_next;
            match_run_reg <= match_run_next;
            vld_bits_reg  <= vld_bits_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Work and result payload.
    always_ff @(posedge aclk) begin
        item_reg           <= item_next;
        rd_addr_reg        <= rd_addr_next;
        cnt_reg            <= cnt_next;
        done_reg           <= done_next;
        res_byte_reg       <= res_byte_next;
        res_err_reg        <= res_err_next;
        res_match_reg      <= res_match_next;
        stream_reg         <= stream_next;
        cmp_reg            <= cmp_next;
        ok_reg             <= ok_next;
        m_byte_out_reg     <= m_byte_out_next;
        m_byte_valid_reg   <= m_byte_valid_next;
        m_last_of_run_reg  <= m_last_of_run_next;
        m_done_count_reg   <= m_done_count_next;
        m_match_found_reg  <= m_match_found_next;
        m_offset_error_reg <= m_offset_error_next;
        m_fill_level_reg   <= m_fill_level_next;
        rd_vld_reg         <= vld_bits_reg[rd_addr_reg];
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= item_reg.data;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_out     = m_byte_out_reg;
    assign m_byte_valid   = m_byte_valid_reg;
    assign m_last_of_run  = m_last_of_run_reg;
    assign m_done_count   = m_done_count_reg;
    assign m_match_found  = m_match_found_reg;
    assign m_offset_error = m_offset_error_reg;
    assign m_fill_level   = m_fill_level_reg;

endmodule

// File: sv/byte_ring_fifo_overwrite_match.sv
// Top level of the byte ring FIFO with overwrite and pattern match.
// Depends on brfom_pkg, brfom_front, brfom_queue and brfom_back.
//
// Usage: command beats enter on the s_ channel, result beats leave on the
// m_ channel; both use valid/ready. The ring length register is written on
// the cfg_ channel; cfg_ready is high only while no command is in flight and
// no result is waiting. A write empties the ring but keeps the stored bytes.
// Sequence: the back-end sequencer takes one command at a time through
// dequeue, execute and respond steps; one that reads the byte store adds a
// read step before respond. Pop copy and peek copy stream their bytes
// through read and respond steps in turn, as each byte waits on the single
// registered read port of the 64-entry byte store. Every pattern byte
// passes a compare step, after a read step when it reads the store; only
// a final pattern byte goes on to respond, the others return to idle.
// Reset clears the pointers, the match flag and the per-slot valid bits,
// so the store reads as all zeros; no clearing pass is needed.
// When the receiver stalls, the result register holds its beat, the
// sequencer waits, and the front stage and a two-entry queue keep taking
// commands until they fill.
module byte_ring_fifo_overwrite_match import brfom_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [REQ_W-1:0]  s_request_count,
    input  logic [CNT_W-1:0]  s_offset,
    input  logic [CNT_W-1:0]  s_pattern_length,
    input  logic              s_pattern_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_out,
    output logic              m_byte_valid,
    output logic              m_last_of_run,
    output logic [CNT_W-1:0]  m_done_count,
    output logic              m_match_found,
    output logic              m_offset_error,
    output logic [CNT_W-1:0]  m_fill_level,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_buffer_length
);

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // Front end: accept and classify.
    brfom_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_request_count  (s_request_count),
        .s_offset         (s_offset),
        .s_pattern_length (s_pattern_length),
        .s_pattern_last   (s_pattern_last),
        .f_valid          (f_valid),
        .f_item           (f_item),
        .f_ready          (f_ready)
    );

    // Decoupling queue.
    brfom_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back end: execute against the ring.
    brfom_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .upstream_busy     (f_valid),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_buffer_length (cfg_buffer_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_byte_out        (m_byte_out),
        .m_byte_valid      (m_byte_valid),
        .m_last_of_run     (m_last_of_run),
        .m_done_count      (m_done_count),
        .m_match_found     (m_match_found),
        .m_offset_error    (m_offset_error),
        .m_fill_level      (m_fill_level)
    );

    // An accepted command keeps the configuration port closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !cfg_ready)
        else $error("cfg_ready high right after a command beat");

    // Only streamed bytes come in runs; any other result ends its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last_of_run)
        else $error("result without byte is not the last of its run");

    // A byte result never carries a match or an offset error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> !m_match_found && !m_offset_error)
        else $error("byte result carries match or error flag");

    // An offset error reports no count and no match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_offset_error |-> (m_done_count == '0) && !m_match_found)
        else $error("offset error result carries count or match");

endmodule
